### hw/rtl/seed_triplet_layer_picker_assert.svh
// Assertion macros shared by the seed picker RTL.
// Both sample on clk and are disabled while arst_n is low.
`ifndef SEED_TRIPLET_LAYER_PICKER_ASSERT_SVH
`define SEED_TRIPLET_LAYER_PICKER_ASSERT_SVH

// Property that must hold on the same clock edge.
`define STLP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define STLP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/stlp_pkg.sv
// ----------------------------------------------------------------------------
// stlp_pkg
// Shared widths, codes and types of the seed triplet layer picker.
// ----------------------------------------------------------------------------
package stlp_pkg;

	localparam int MAX_PICKS  = 32;
	localparam int SEED_LEN   = 3;
	localparam int SLOT_W     = $clog2(MAX_PICKS);
	localparam int PICK_CNT_W = $clog2(MAX_PICKS + 1);

	localparam int IDX_W  = 24;
	localparam int KEY_W  = 32;
	localparam int POS_W  = 20;
	localparam int DIST_W = 36;
	localparam int MODE_W = 2;
	localparam int DIFF_W = POS_W + 1;
	localparam int SQ_W   = 2 * POS_W;

	localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_INNER  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SPREAD = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

	localparam logic [1:0] REG_MODE     = 2'd0;
	localparam logic [1:0] REG_MIN_DIST = 2'd1;

	// Candidate as it travels down the cell chain.
	typedef struct packed {
		logic                    vld;
		logic [IDX_W-1:0]        index;
		logic [KEY_W-1:0]        layer;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic                    elig;     // may become a pick
		logic                    spread;   // picking runs past the first three cells
		logic                    blocked;  // failed against an earlier pick
		logic                    claimed;  // already stored in a cell
		logic                    last;
	} cand_t;

	typedef struct packed {
		logic clear;  // drop all picks
		logic shift;  // move pick indices one cell toward the head
	} cell_ctl_t;

endpackage

### hw/rtl/stlp_cell.sv
// ----------------------------------------------------------------------------
// stlp_cell
// One pick slot: compares passing candidates against its pick, or claims it.
// ----------------------------------------------------------------------------
module stlp_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  stlp_pkg::cand_t              cand_in,
	input  logic                         early,
	input  logic [stlp_pkg::DIST_W-1:0]  min_dist_sq,
	input  stlp_pkg::cell_ctl_t          ctl,
	input  logic [stlp_pkg::IDX_W-1:0]   next_index,
	output stlp_pkg::cand_t              cand_out,
	output logic [stlp_pkg::IDX_W-1:0]   pick_index
);

	logic                              pick_vld_q;
	logic [stlp_pkg::IDX_W-1:0]        pick_index_q;
	logic [stlp_pkg::KEY_W-1:0]        pick_layer_q;
	logic signed [stlp_pkg::POS_W-1:0] pick_x_q;
	logic signed [stlp_pkg::POS_W-1:0] pick_y_q;

	stlp_pkg::cand_t                   cand_s1;
	logic                              cmp_s1;
	logic                              leq_s1;
	logic [stlp_pkg::SQ_W-1:0]         dxsq_s1;
	logic [stlp_pkg::SQ_W-1:0]         dysq_s1;
	stlp_pkg::cand_t                   cand_out_q;

	logic                               active;
	logic                               claim;
	stlp_pkg::cand_t                    cand_a;
	logic signed [stlp_pkg::DIFF_W-1:0] dx;
	logic signed [stlp_pkg::DIFF_W-1:0] dy;
	logic signed [2*stlp_pkg::DIFF_W-1:0] dxx;
	logic signed [2*stlp_pkg::DIFF_W-1:0] dyy;
	logic [stlp_pkg::SQ_W:0]            dist_sq;
	logic                               reject;
	stlp_pkg::cand_t                    cand_b;

	// first stage: claim an empty slot, or square the distance to the pick
	always_comb begin
		active = cand_in.vld && cand_in.elig && !cand_in.blocked && !cand_in.claimed;
		claim  = active && !pick_vld_q && (early || cand_in.spread);
		cand_a = cand_in;
		cand_a.claimed = cand_in.claimed || claim;
		dx  = {cand_in.x[stlp_pkg::POS_W-1], cand_in.x} - {pick_x_q[stlp_pkg::POS_W-1], pick_x_q};
		dy  = {cand_in.y[stlp_pkg::POS_W-1], cand_in.y} - {pick_y_q[stlp_pkg::POS_W-1], pick_y_q};
		dxx = dx * dx;
		dyy = dy * dy;
	end

	// second stage: sum and threshold
	always_comb begin
		dist_sq = {1'b0, dxsq_s1} + {1'b0, dysq_s1};
		reject  = cmp_s1 && (leq_s1 ||
			(dist_sq < {{(stlp_pkg::SQ_W + 1 - stlp_pkg::DIST_W){1'b0}}, min_dist_sq}));
		cand_b = cand_s1;
		cand_b.blocked = cand_s1.blocked || reject;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pick_vld_q <= 1'b0;
			cand_s1    <= '0;
			cmp_s1     <= 1'b0;
			cand_out_q <= '0;
		end else begin
			if (ctl.clear) begin
				pick_vld_q <= 1'b0;
			end else if (claim) begin
				pick_vld_q <= 1'b1;
			end
			cand_s1    <= cand_a;
			cmp_s1     <= active && pick_vld_q;
			cand_out_q <= cand_b;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			pick_index_q <= next_index;
		end else if (claim) begin
			pick_index_q <= cand_in.index;
		end
		if (claim) begin
			pick_layer_q <= cand_in.layer;
			pick_x_q     <= cand_in.x;
			pick_y_q     <= cand_in.y;
		end
		leq_s1  <= (cand_in.layer == pick_layer_q);
		dxsq_s1 <= dxx[stlp_pkg::SQ_W-1:0];
		dysq_s1 <= dyy[stlp_pkg::SQ_W-1:0];
	end

	assign cand_out   = cand_out_q;
	assign pick_index = pick_index_q;

endmodule

### hw/rtl/seed_triplet_layer_picker.sv
// ----------------------------------------------------------------------------
// seed_triplet_layer_picker
// Picks space points one per layer with a minimum spacing and reports a seed.
// ----------------------------------------------------------------------------
// Usage:
//   Candidates of one track enter on start while busy is low, one per cycle.
//   Each runs down a chain of 32 pick cells, two register stages per cell
//   (squares, then sum and compare), behind an entry register. Layer and
//   distance checks against all picks thus happen in flight, and back-to-back
//   candidates see each other's picks in order.
//   Accepting a candidate with last_candidate set raises busy. Once it has
//   left the chain, the pick indices are shifted out of the cells, one per
//   cycle, until the last seed pick is reached; then done strobes for one
//   cycle with the seed, the track state clears and busy drops in that same
//   cycle.
//   A spread seed is shifted out to its last pick, an innermost seed to
//   its third; a first-three seed or a failed one is sent at once. Within
//   a track: one candidate per cycle.
//   Results cannot be held off; the receiver must take done when it comes.
//   Registers must be written on cfg_we while the block is idle (unchecked).
//   After reset: mode 0, min_dist_sq 0, no picks, block idle.
// ----------------------------------------------------------------------------
`include "seed_triplet_layer_picker_assert.svh"

module seed_triplet_layer_picker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [stlp_pkg::IDX_W-1:0]        point_index,
	input  logic                              has_link,
	input  logic [stlp_pkg::KEY_W-1:0]        layer_key,
	input  logic signed [stlp_pkg::POS_W-1:0] x_pos,
	input  logic signed [stlp_pkg::POS_W-1:0] y_pos,
	input  logic                              last_candidate,
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_index,
	input  logic [stlp_pkg::DIST_W-1:0]       cfg_data,
	output logic                              done,
	output logic                              seed_valid,
	output logic [stlp_pkg::IDX_W-1:0]        first_index,
	output logic [stlp_pkg::IDX_W-1:0]        middle_index,
	output logic [stlp_pkg::IDX_W-1:0]        last_index,
	output logic                              picks_truncated
);

	localparam logic [1:0] ST_RUN    = 2'd0;
	localparam logic [1:0] ST_DRAIN  = 2'd1;
	localparam logic [1:0] ST_UNLOAD = 2'd2;

	logic [1:0]                           state_q;
	logic [stlp_pkg::MODE_W-1:0]          mode_q;
	logic [stlp_pkg::DIST_W-1:0]          min_dist_q;
	logic [stlp_pkg::MODE_W-1:0]          seed_mode_q;
	logic [1:0]                           cand_cnt_q;
	logic [stlp_pkg::IDX_W-1:0]           lead_q [stlp_pkg::SEED_LEN];
	logic [stlp_pkg::PICK_CNT_W-1:0]      pc_q;
	logic                                 ovf_q;
	logic [stlp_pkg::SLOT_W-1:0]          k_q;
	logic [stlp_pkg::IDX_W-1:0]           first_q;
	logic [stlp_pkg::IDX_W-1:0]           mid_q;
	stlp_pkg::cand_t                      entry_q;

	logic                                 done_q;
	logic                                 seed_valid_q;
	logic [stlp_pkg::IDX_W-1:0]           first_index_q;
	logic [stlp_pkg::IDX_W-1:0]           middle_index_q;
	logic [stlp_pkg::IDX_W-1:0]           last_index_q;
	logic                                 truncated_q;

	stlp_pkg::cand_t                      chain [stlp_pkg::MAX_PICKS+1];
	logic [stlp_pkg::IDX_W-1:0]           idx_w [stlp_pkg::MAX_PICKS];
	stlp_pkg::cell_ctl_t                  ctl;

	logic                                 take;
	logic                                 picking;
	stlp_pkg::cand_t                      exit_c;
	logic [stlp_pkg::PICK_CNT_W-1:0]      k_ext;
	logic [stlp_pkg::PICK_CNT_W-1:0]      mid_pos;
	logic [stlp_pkg::PICK_CNT_W-1:0]      last_pos;
	logic                                 seed_ok;
	logic                                 emit;
	logic                                 emit_valid;
	logic [stlp_pkg::IDX_W-1:0]           emit_first;
	logic [stlp_pkg::IDX_W-1:0]           emit_mid;
	logic [stlp_pkg::IDX_W-1:0]           emit_last;

	assign busy    = (state_q != ST_RUN);
	assign take    = start && !busy;
	assign picking = (mode_q == stlp_pkg::MODE_INNER) || (mode_q == stlp_pkg::MODE_SPREAD);
	assign exit_c  = chain[stlp_pkg::MAX_PICKS];
	assign chain[0] = entry_q;

	genvar gi;
	generate
		for (gi = 0; gi < stlp_pkg::MAX_PICKS; gi++) begin : g_cell
			logic [stlp_pkg::IDX_W-1:0] nxt;
			if (gi == stlp_pkg::MAX_PICKS - 1) begin : g_tail
				assign nxt = '0;
			end else begin : g_mid
				assign nxt = idx_w[gi+1];
			end
			stlp_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.cand_in     (chain[gi]),
				.early       (gi < stlp_pkg::SEED_LEN),
				.min_dist_sq (min_dist_q),
				.ctl         (ctl),
				.next_index  (nxt),
				.cand_out    (chain[gi+1]),
				.pick_index  (idx_w[gi])
			);
		end
	endgenerate

	// seed selection while the pick indices stream out of the head cell
	always_comb begin
		k_ext   = {{(stlp_pkg::PICK_CNT_W - stlp_pkg::SLOT_W){1'b0}}, k_q};
		// innermost seed takes the first three picks, spread seed first/middle/last
		if (seed_mode_q == stlp_pkg::MODE_INNER) begin
			mid_pos  = stlp_pkg::PICK_CNT_W'(1);
			last_pos = stlp_pkg::PICK_CNT_W'(stlp_pkg::SEED_LEN - 1);
		end else begin
			mid_pos  = pc_q >> 1;
			last_pos = pc_q - 1'b1;
		end
		seed_ok = (cand_cnt_q == 2'd3) &&
			((seed_mode_q == stlp_pkg::MODE_FIRST) ||
			 (((seed_mode_q == stlp_pkg::MODE_INNER) || (seed_mode_q == stlp_pkg::MODE_SPREAD))
			  && (pc_q >= stlp_pkg::PICK_CNT_W'(stlp_pkg::SEED_LEN))));
		emit       = 1'b0;
		emit_valid = 1'b0;
		emit_first = '0;
		emit_mid   = '0;
		emit_last  = '0;
		if (state_q == ST_UNLOAD) begin
			priority if (!seed_ok) begin
				emit = 1'b1;
			end else if (seed_mode_q == stlp_pkg::MODE_FIRST) begin
				emit       = 1'b1;
				emit_valid = 1'b1;
				emit_first = lead_q[0];
				emit_mid   = lead_q[1];
				emit_last  = lead_q[2];
			end else if (k_ext == last_pos) begin
				emit       = 1'b1;
				emit_valid = 1'b1;
				emit_first = first_q;
				emit_mid   = (k_ext == mid_pos) ? idx_w[0] : mid_q;
				emit_last  = idx_w[0];
			end else begin
				emit = 1'b0;
			end
		end
		ctl.clear = emit;
		ctl.shift = (state_q == ST_UNLOAD) && !emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_RUN;
			mode_q       <= stlp_pkg::MODE_FIRST;
			min_dist_q   <= '0;
			seed_mode_q  <= stlp_pkg::MODE_FIRST;
			cand_cnt_q   <= '0;
			pc_q         <= '0;
			ovf_q        <= 1'b0;
			k_q          <= '0;
			entry_q      <= '0;
			done_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					stlp_pkg::REG_MODE:     mode_q     <= cfg_data[stlp_pkg::MODE_W-1:0];
					stlp_pkg::REG_MIN_DIST: min_dist_q <= cfg_data;
					default: ;
				endcase
			end

			entry_q.vld     <= take;
			entry_q.elig    <= has_link && picking;
			entry_q.spread  <= (mode_q == stlp_pkg::MODE_SPREAD);
			entry_q.blocked <= 1'b0;
			entry_q.claimed <= 1'b0;
			entry_q.last    <= last_candidate;
			entry_q.index   <= point_index;
			entry_q.layer   <= layer_key;
			entry_q.x       <= x_pos;
			entry_q.y       <= y_pos;

			if (take && (cand_cnt_q != 2'd3)) begin
				cand_cnt_q <= cand_cnt_q + 2'd1;
			end

			if (exit_c.vld && exit_c.claimed) begin
				pc_q <= pc_q + 1'b1;
			end
			// qualified but no free slot left
			if (exit_c.vld && exit_c.elig && exit_c.spread && !exit_c.blocked && !exit_c.claimed) begin
				ovf_q <= 1'b1;
			end

			done_q <= emit;

			unique case (state_q)
				ST_RUN: begin
					if (take && last_candidate) begin
						state_q     <= ST_DRAIN;
						seed_mode_q <= mode_q;
					end
				end
				ST_DRAIN: begin
					if (exit_c.vld && exit_c.last) begin
						state_q <= ST_UNLOAD;
						k_q     <= '0;
					end
				end
				ST_UNLOAD: begin
					if (emit) begin
						state_q    <= ST_RUN;
						cand_cnt_q <= '0;
						pc_q       <= '0;
						ovf_q      <= 1'b0;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take && (cand_cnt_q != 2'd3)) begin
			lead_q[cand_cnt_q] <= point_index;
		end
		if (state_q == ST_UNLOAD) begin
			if (k_q == '0) begin
				first_q <= idx_w[0];
			end
			if (k_ext == mid_pos) begin
				mid_q <= idx_w[0];
			end
		end
		if (emit) begin
			seed_valid_q   <= emit_valid;
			first_index_q  <= emit_first;
			middle_index_q <= emit_mid;
			last_index_q   <= emit_last;
			truncated_q    <= ovf_q;
		end
	end

	assign done            = done_q;
	assign seed_valid      = seed_valid_q;
	assign first_index     = first_index_q;
	assign middle_index    = middle_index_q;
	assign last_index      = last_index_q;
	assign picks_truncated = truncated_q;

	`STLP_ASSERT(a_pick_cnt_max, pc_q <= stlp_pkg::PICK_CNT_W'(stlp_pkg::MAX_PICKS), "pick count past depth")
	`STLP_ASSERT(a_last_exit_drain, (exit_c.vld && exit_c.last) |-> (state_q == ST_DRAIN), "last request left chain outside drain")
	`STLP_ASSERT(a_valid_needs_three, (done && seed_valid) |-> ($past(cand_cnt_q) == 2'd3), "seed from fewer than three requests")
	`STLP_ASSERT_NEXT(a_track_cleared, emit, (state_q == ST_RUN) && (pc_q == '0) && !ovf_q && done, "track state not cleared after seed")

endmodule
